/* design/button_debounce_longpress_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the button debouncer
// Shared property shapes, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONGPRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_MACROS_SVH

// Same-cycle implication.
`define BDL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bdl_pkg.sv */
// ---------------------------------------------------------------------------
// Button debouncer package
// Shared types, register indexes and event codes.
// ---------------------------------------------------------------------------
package bdl_pkg;

	localparam int CntW   = 17;
	localparam int RegW   = 16;
	localparam int IndexW = 8;

	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	localparam logic [IndexW-1:0] REG_ACTIVE_HIGH   = 8'd0;
	localparam logic [IndexW-1:0] REG_RATE_LIMIT_MS = 8'd1;
	localparam logic [IndexW-1:0] REG_DEBOUNCE_MS   = 8'd2;
	localparam logic [IndexW-1:0] REG_LONGPRESS_MS  = 8'd3;

	typedef enum logic [1:0] {
		EV_NONE       = 2'd0,
		EV_ACTIVATE   = 2'd1,
		EV_DEACTIVATE = 2'd2,
		EV_LONG_PRESS = 2'd3
	} event_t;

	typedef struct packed {
		logic            active_high;
		logic [RegW-1:0] rate_limit_ms;
		logic [RegW-1:0] debounce_ms;
		logic [RegW-1:0] longpress_ms;
	} cfg_t;

	typedef struct packed {
		logic   is_pressed;
		logic   is_long_press;
		event_t event_code;
	} result_t;

endpackage

/* design/button_debounce_longpress.sv */
// ---------------------------------------------------------------------------
// Debounced push-button with long-press detection
// Top level: input register, tick logic, result register and config port.
// ---------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the raw pin level, and
// each one yields exactly one result beat with the debounced state, the
// long-press flag and an event code. The block takes one beat per clock
// cycle for as long as the output side keeps up. A beat is taken into the
// input register at the edge that accepts it and moves on into the result
// register once that register is free; its result is offered from there.
// The rate is set by the tick logic, which updates its flags and
// saturating counters once per beat, so one tick can follow another
// directly. The output register parts the two sides, so a new beat is
// still taken while a finished result waits, as long as the input
// register has room. Configuration should only be written while no beat
// is in flight; writes to an unknown register index are ignored.
`include "button_debounce_longpress_macros.svh"

module button_debounce_longpress (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bdl_pkg::IndexW-1:0] cfg_index,
	input  logic [bdl_pkg::RegW-1:0]   cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       pin_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       is_pressed,
	output logic                       is_long_press,
	output logic [1:0]                 event_code
);
	import bdl_pkg::*;

	cfg_t    cfg;
	result_t tick_result;
	result_t result_q;

	logic valid_s1, level_s1;
	logic out_valid_q;
	logic out_free, tick_fire, in_take;

	// The result register can load when it is empty or being drained this
	// cycle; the held tick then moves on and updates the state.
	assign out_free  = !out_valid_q || !out_stall;
	assign tick_fire = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;

	bdl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register: holds one tick until the tick logic can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (tick_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			level_s1 <= pin_level;
		end
	end

	bdl_tick_logic u_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick_en (tick_fire),
		.level   (level_s1),
		.result  (tick_result)
	);

	// Result register: the beat waits here while the output side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= tick_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			result_q <= tick_result;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_pressed    = result_q.is_pressed;
	assign is_long_press = result_q.is_long_press;
	assign event_code    = result_q.event_code;

	// An activation leaves the button pressed without a long press yet.
	`BDL_ASSERT_IMPLIES(a_activate_state, clk, arst_n,
		out_valid && (event_code == EV_ACTIVATE), is_pressed && !is_long_press,
		"activation beat does not show a fresh press")
	// A deactivation clears both flags.
	`BDL_ASSERT_IMPLIES(a_deactivate_state, clk, arst_n,
		out_valid && (event_code == EV_DEACTIVATE), !is_pressed && !is_long_press,
		"deactivation beat leaves a flag set")
	// The long-press flag is only ever set on a pressed button.
	`BDL_ASSERT_IMPLIES(a_long_needs_press, clk, arst_n,
		out_valid && is_long_press, is_pressed,
		"long press reported without a press")
	// An accepted tick is held in the input register on the next cycle.
	`BDL_ASSERT_NEXT(a_take_holds, clk, arst_n,
		in_take, valid_s1,
		"accepted tick lost from the input register")

endmodule

/* design/bdl_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Button debouncer configuration registers
// Plain write port; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
module bdl_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bdl_pkg::IndexW-1:0] cfg_index,
	input  logic [bdl_pkg::RegW-1:0]   cfg_wdata,
	output bdl_pkg::cfg_t              cfg
);
	import bdl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high   <= 1'b1;
			cfg_q.rate_limit_ms <= '0;
			cfg_q.debounce_ms   <= '0;
			cfg_q.longpress_ms  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_HIGH:   cfg_q.active_high   <= cfg_wdata[0];
				REG_RATE_LIMIT_MS: cfg_q.rate_limit_ms <= cfg_wdata;
				REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_wdata;
				REG_LONGPRESS_MS:  cfg_q.longpress_ms  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/bdl_tick_logic.sv */
// ---------------------------------------------------------------------------
// Button debouncer tick logic
// Holds the debounce state and works out one tick per enabled cycle.
// ---------------------------------------------------------------------------
module bdl_tick_logic (
	input  logic             clk,
	input  logic             arst_n,
	input  bdl_pkg::cfg_t    cfg,
	input  logic             tick_en,
	input  logic             level,
	output bdl_pkg::result_t result
);
	import bdl_pkg::*;

	logic            pressed_q, long_q;
	logic [CntW-1:0] since_change_q, since_sample_q;

	logic            pressed_d, long_d;
	logic [CntW-1:0] since_change_d, since_sample_d;
	logic [CntW-1:0] change_inc, sample_inc;
	logic            take_sample, settled, active;
	event_t          ev;

	always_comb begin
		change_inc = (since_change_q == CntMax) ? CntMax : since_change_q + 1'b1;
		sample_inc = (since_sample_q == CntMax) ? CntMax : since_sample_q + 1'b1;
		take_sample = sample_inc > {1'b0, cfg.rate_limit_ms};
		settled     = change_inc > {1'b0, cfg.debounce_ms};
		active      = (level == cfg.active_high);

		pressed_d      = pressed_q;
		long_d         = long_q;
		since_change_d = change_inc;
		since_sample_d = sample_inc;
		ev             = EV_NONE;

		if (take_sample) begin
			since_sample_d = '0;
			if (settled && !pressed_q && active) begin
				pressed_d      = 1'b1;
				since_change_d = '0;
				ev             = EV_ACTIVATE;
			end else if (settled && pressed_q && !active) begin
				pressed_d      = 1'b0;
				long_d         = 1'b0;
				since_change_d = '0;
				ev             = EV_DEACTIVATE;
			end else if (pressed_q && !long_q &&
			             (change_inc > {1'b0, cfg.longpress_ms})) begin
				long_d = 1'b1;
				ev     = EV_LONG_PRESS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q      <= 1'b0;
			long_q         <= 1'b0;
			since_change_q <= '0;
			since_sample_q <= '0;
		end else if (tick_en) begin
			pressed_q      <= pressed_d;
			long_q         <= long_d;
			since_change_q <= since_change_d;
			since_sample_q <= since_sample_d;
		end
	end

	assign result.is_pressed    = pressed_d;
	assign result.is_long_press = long_d;
	assign result.event_code    = ev;

endmodule
